[rtl/core/array_linked_list_manager_unit_macros.svh]
// Assertion macros shared by the linked list manager RTL.
`ifndef ARRAY_LINKED_LIST_MANAGER_UNIT_MACROS_SVH
`define ARRAY_LINKED_LIST_MANAGER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Check that an antecedent implies a consequent in the same cycle.
`define ALM_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define ALM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ALM_ASSERT_SAME(lbl, ante, cons, msg)
`define ALM_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[rtl/core/alm_pkg.sv]
// Shared constants and codes of the linked list manager.
package alm_pkg;

	localparam int unsigned POOL_NODES_DEF = 16;
	localparam int unsigned DEF_IDX_W      = $clog2(POOL_NODES_DEF);
	localparam int unsigned DEF_LINK_W     = $clog2(POOL_NODES_DEF + 1);

	localparam int unsigned NAME_W   = 64;
	localparam int unsigned SCHOOL_W = 16;
	localparam int unsigned DATA_W   = NAME_W + SCHOOL_W;

	localparam logic [SCHOOL_W-1:0] SCHOOL_BLANK = '1;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_DELETE = 1'b1;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;
	localparam logic [1:0] STAT_BAD   = 2'd3;

endpackage

[rtl/core/alm_req_if.sv]
// Request and response channel interfaces of the linked list manager.
interface alm_req_if
	import alm_pkg::*;
	#(parameter int unsigned IDX_W = DEF_IDX_W)
	();
	logic                       valid;
	logic                       ready;
	logic                       cmd;
	logic                       at_head;
	logic [IDX_W-1:0]           pred_node;
	logic [NAME_W-1:0]          name_in;
	logic signed [SCHOOL_W-1:0] school_in;

	modport source (output valid, cmd, at_head, pred_node, name_in, school_in, input ready);
	modport sink   (input valid, cmd, at_head, pred_node, name_in, school_in, output ready);
endinterface

interface alm_rsp_if
	import alm_pkg::*;
	#(parameter int unsigned IDX_W = DEF_IDX_W,
	  parameter int unsigned LINK_W = DEF_LINK_W)
	();
	logic                       valid;
	logic                       ready;
	logic [1:0]                 status;
	logic [IDX_W-1:0]           node_index;
	logic [NAME_W-1:0]          name_out;
	logic signed [SCHOOL_W-1:0] school_out;
	logic [LINK_W-1:0]          head_node;
	logic [LINK_W-1:0]          free_head;

	modport source (output valid, status, node_index, name_out, school_out, head_node,
		free_head, input ready);
	modport sink   (input valid, status, node_index, name_out, school_out, head_node,
		free_head, output ready);
endinterface

[rtl/core/alm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module alm_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/core/array_linked_list_manager_unit.sv]
// Top level of the linked list manager: sequencer, pointers and node stores.
//
//  channel | dir | handshake   | payload
//  --------+-----+-------------+-----------------------------------------------
//  req     | in  | valid/ready | cmd, at_head, pred_node, name_in, school_in
//  rsp     | out | valid/ready | status, node_index, name_out, school_out,
//          |     |             | head_node, free_head
//
//  One transaction at a time. Operations at the list head pass through S_A to
//  S_DONE before the result register; operations after a predecessor pass
//  through S_A, S_B and S_C, set by the single read and single write port of
//  the link RAM. Refused operations go straight to S_DONE, or through S_A for
//  a delete whose predecessor has no successor. After reset a clearing pass
//  writes each node's reset link and blank data, one node a cycle; requests
//  wait until it ends. A stalled response holds the sequencer in its final
//  state until the result register is free.
`include "array_linked_list_manager_unit_macros.svh"

module array_linked_list_manager_unit
	import alm_pkg::*;
	#(parameter int unsigned POOL_NODES = POOL_NODES_DEF)
	(
	input  logic     clk,
	input  logic     arst_n,
	alm_req_if.sink  req,
	alm_rsp_if.source rsp
);

	localparam int unsigned IDX_W  = $clog2(POOL_NODES);
	localparam int unsigned LINK_W = $clog2(POOL_NODES + 1);
	localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(POOL_NODES);
	localparam logic [DATA_W-1:0] DATA_BLANK = {{NAME_W{1'b0}}, SCHOOL_BLANK};

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_A    = 3'd1;
	localparam logic [2:0] S_B    = 3'd2;
	localparam logic [2:0] S_C    = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;
	localparam logic [2:0] S_INIT = 3'd5;

	// sequencer and pointers
	logic [2:0]         state_q;
	logic [LINK_W-1:0]  head_q;
	logic [LINK_W-1:0]  free_q;
	logic [IDX_W-1:0]   init_q;

	// latched transaction and working values
	logic                       cmd_q;
	logic                       at_head_q;
	logic [IDX_W-1:0]           pred_q;
	logic [NAME_W-1:0]          name_in_q;
	logic [SCHOOL_W-1:0]        school_in_q;
	logic [IDX_W-1:0]           node_q;
	logic [LINK_W-1:0]          tmp_q;
	logic [1:0]                 status_q;
	logic [NAME_W-1:0]          name_out_q;
	logic [SCHOOL_W-1:0]        school_out_q;

	// response register
	logic                rsp_vld_q;
	logic [1:0]          rsp_status_q;
	logic [IDX_W-1:0]    rsp_node_q;
	logic [NAME_W-1:0]   rsp_name_q;
	logic [SCHOOL_W-1:0] rsp_school_q;
	logic [LINK_W-1:0]   rsp_head_q;
	logic [LINK_W-1:0]   rsp_free_q;

	// memory ports
	logic              link_re, link_we;
	logic [IDX_W-1:0]  link_raddr, link_waddr;
	logic [LINK_W-1:0] link_wdata, link_rdata;
	logic              data_re, data_we;
	logic [IDX_W-1:0]  data_raddr, data_waddr;
	logic [DATA_W-1:0] data_wdata, data_rdata;

	logic              req_fire;
	logic              rsp_load;
	logic [1:0]        acc_status;
	logic              pred_bad;
	logic [IDX_W-1:0]  free_idx;
	logic [IDX_W-1:0]  head_idx;
	logic [LINK_W-1:0] link_rd;
	logic [IDX_W-1:0]  link_rd_idx;
	logic              link_rd_none;
	logic [NAME_W-1:0] data_rd_name;
	logic [SCHOOL_W-1:0] data_rd_school;

	assign req.ready = (state_q == S_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign rsp_load  = (state_q == S_DONE) && (!rsp_vld_q || rsp.ready);

	assign free_idx = free_q[IDX_W-1:0];
	assign head_idx = head_q[IDX_W-1:0];
	assign pred_bad = (LINK_W'(req.pred_node) >= LINK_NONE);

	assign link_rd      = link_rdata;
	assign link_rd_idx  = link_rd[IDX_W-1:0];
	assign link_rd_none = (link_rd >= LINK_NONE);

	assign data_rd_name   = data_rdata[DATA_W-1:SCHOOL_W];
	assign data_rd_school = data_rdata[SCHOOL_W-1:0];

	// status decided at acceptance; a missing successor is found later
	always_comb begin
		acc_status = STAT_OK;
		if (req.cmd == CMD_INSERT) begin
			if (free_q >= LINK_NONE) begin
				acc_status = STAT_FULL;
			end else if (!req.at_head && pred_bad) begin
				acc_status = STAT_BAD;
			end
		end else begin
			if (head_q >= LINK_NONE) begin
				acc_status = STAT_EMPTY;
			end else if (!req.at_head && pred_bad) begin
				acc_status = STAT_BAD;
			end
		end
	end

	// Memory accesses per step. Reads and writes of one operation never
	// touch the same entry in overlapping cycles, so no forwarding is needed.
	always_comb begin
		link_re       = 1'b0;
		link_raddr    = '0;
		link_we       = 1'b0;
		link_waddr    = '0;
		link_wdata    = '0;
		data_re       = 1'b0;
		data_raddr    = '0;
		data_we       = 1'b0;
		data_waddr    = '0;
		data_wdata    = '0;
		unique case (state_q)
			S_INIT: begin
				// write the reset link i+1 and blank data, one node a cycle
				link_we    = 1'b1;
				link_waddr = init_q;
				link_wdata = LINK_W'(init_q) + LINK_W'(1);
				data_we    = 1'b1;
				data_waddr = init_q;
				data_wdata = DATA_BLANK;
			end
			S_IDLE: begin
				if (req_fire && (acc_status == STAT_OK)) begin
					link_re = 1'b1;
					if (req.cmd == CMD_INSERT) begin
						link_raddr = free_idx;
					end else if (req.at_head) begin
						link_raddr = head_idx;
						data_re    = 1'b1;
						data_raddr = head_idx;
					end else begin
						link_raddr = req.pred_node;
					end
				end
			end
			S_A: begin
				if (cmd_q == CMD_INSERT) begin
					if (at_head_q) begin
						// link the new node in front of the old head
						link_we    = 1'b1;
						link_waddr = node_q;
						link_wdata = head_q;
						data_we    = 1'b1;
						data_waddr = node_q;
						data_wdata = {name_in_q, school_in_q};
					end else begin
						link_re    = 1'b1;
						link_raddr = pred_q;
					end
				end else begin
					if (at_head_q) begin
						// push the old head onto the free list
						link_we    = 1'b1;
						link_waddr = node_q;
						link_wdata = free_q;
						data_we    = 1'b1;
						data_waddr = node_q;
						data_wdata = DATA_BLANK;
					end else if (!link_rd_none) begin
						link_re    = 1'b1;
						link_raddr = link_rd_idx;
						data_re    = 1'b1;
						data_raddr = link_rd_idx;
					end
				end
			end
			S_B: begin
				link_we = 1'b1;
				if (cmd_q == CMD_INSERT) begin
					link_waddr = node_q;
					link_wdata = link_rd;
					data_we    = 1'b1;
					data_waddr = node_q;
					data_wdata = {name_in_q, school_in_q};
				end else begin
					// bypass the victim
					link_waddr = pred_q;
					link_wdata = link_rd;
					data_we    = 1'b1;
					data_waddr = node_q;
					data_wdata = DATA_BLANK;
				end
			end
			S_C: begin
				link_we = 1'b1;
				if (cmd_q == CMD_INSERT) begin
					link_waddr = pred_q;
					link_wdata = LINK_W'(node_q);
				end else begin
					link_waddr = node_q;
					link_wdata = free_q;
				end
			end
			default: begin
			end
		endcase
	end

	alm_ram #(
		.WIDTH (LINK_W),
		.DEPTH (POOL_NODES)
	) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.re    (link_re),
		.raddr (link_raddr),
		.rdata (link_rdata)
	);

	alm_ram #(
		.WIDTH (DATA_W),
		.DEPTH (POOL_NODES)
	) u_data_ram (
		.clk   (clk),
		.we    (data_we),
		.waddr (data_waddr),
		.wdata (data_wdata),
		.re    (data_re),
		.raddr (data_raddr),
		.rdata (data_rdata)
	);

	// control state, pointers and clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_INIT;
			head_q     <= LINK_NONE;
			free_q     <= '0;
			init_q     <= '0;
			rsp_vld_q  <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end

			unique case (state_q)
				S_INIT: begin
					init_q <= init_q + IDX_W'(1);
					if (init_q == IDX_W'(POOL_NODES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_fire) begin
						state_q <= (acc_status == STAT_OK) ? S_A : S_DONE;
					end
				end
				S_A: begin
					if (cmd_q == CMD_INSERT) begin
						if (at_head_q) begin
							free_q  <= link_rd;
							head_q  <= LINK_W'(node_q);
							state_q <= S_DONE;
						end else begin
							state_q <= S_B;
						end
					end else begin
						if (at_head_q) begin
							head_q  <= link_rd;
							free_q  <= LINK_W'(node_q);
							state_q <= S_DONE;
						end else begin
							state_q <= link_rd_none ? S_DONE : S_B;
						end
					end
				end
				S_B: begin
					state_q <= S_C;
				end
				S_C: begin
					free_q  <= (cmd_q == CMD_INSERT) ? tmp_q : LINK_W'(node_q);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// transaction payload, working registers and response register
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					cmd_q        <= req.cmd;
					at_head_q    <= req.at_head;
					pred_q       <= req.pred_node;
					name_in_q    <= req.name_in;
					school_in_q  <= req.school_in;
					status_q     <= acc_status;
					name_out_q   <= '0;
					school_out_q <= '0;
					if (acc_status != STAT_OK) begin
						node_q <= '0;
					end else if (req.cmd == CMD_INSERT) begin
						node_q <= free_idx;
					end else if (req.at_head) begin
						node_q <= head_idx;
					end else begin
						node_q <= '0;
					end
				end
			end
			S_A: begin
				if (cmd_q == CMD_INSERT) begin
					tmp_q <= link_rd;
				end else if (at_head_q) begin
					name_out_q   <= data_rd_name;
					school_out_q <= data_rd_school;
				end else if (link_rd_none) begin
					// predecessor has no successor: refuse
					status_q <= STAT_BAD;
				end else begin
					node_q <= link_rd_idx;
				end
			end
			S_B: begin
				if (cmd_q == CMD_DELETE) begin
					name_out_q   <= data_rd_name;
					school_out_q <= data_rd_school;
				end
			end
			default: begin
			end
		endcase

		if (rsp_load) begin
			rsp_status_q <= status_q;
			rsp_node_q   <= node_q;
			rsp_name_q   <= name_out_q;
			rsp_school_q <= school_out_q;
			rsp_head_q   <= head_q;
			rsp_free_q   <= free_q;
		end
	end

	assign rsp.valid      = rsp_vld_q;
	assign rsp.status     = rsp_status_q;
	assign rsp.node_index = rsp_node_q;
	assign rsp.name_out   = rsp_name_q;
	assign rsp.school_out = $signed(rsp_school_q);
	assign rsp.head_node  = rsp_head_q;
	assign rsp.free_head  = rsp_free_q;

	`ALM_ASSERT_NEXT(a_accept_leaves_idle, req_fire, state_q != S_IDLE, "accepted transaction left sequencer idle")
	`ALM_ASSERT_NEXT(a_done_holds, (state_q == S_DONE) && rsp_vld_q && !rsp.ready, state_q == S_DONE, "result dropped while response stalled")
	`ALM_ASSERT_SAME(a_link_wr_range, link_we, LINK_W'(link_waddr) < LINK_NONE, "link write outside the pool")
	`ALM_ASSERT_SAME(a_c_after_b, state_q == S_C, $past(state_q) == S_B, "final link write not preceded by first")

endmodule
